// ===== sv/spq_pkg.sv =====
// Shared types, sizes and codes for the sorted priority queue.
package spq_pkg;

  // Number of entries held in the cell row.
  localparam int CAPACITY = 64;
  // Width of the fill count, able to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Operation codes carried on the input side.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  // One stored entry: a two's complement priority and a value.
  typedef struct packed {
    logic [31:0] prio;
    logic [31:0] value;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// One cell of the sorted row: holds an entry and shifts toward either neighbor.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    new_entry,
  input  logic               occ,
  input  logic               prev_keep,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               keep,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_next
);

  // Keep the entry on a push when it is held and ranks at or above the new one.
  assign keep = occ && ($signed(entry.prio) >= $signed(new_entry.prio));

  // Pick the next content: hold, take the new item, or shift from a neighbor.
  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (keep) begin
        entry_next = entry;
      end else if (prev_keep) begin
        entry_next = new_entry;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell row, fill count and result register.
//
// Usage: the input stream carries one command per transfer. tuser[0] is the
// opcode (0 push, 1 pop); tdata holds the value and the priority. Every
// command yields exactly one result transfer on the output stream: tuser is
// the status, tdata the popped value, the new top value, an empty flag and
// the entry count.
// Entries sit in a row of CAPACITY cells sorted by priority, highest in cell
// 0; a push makes each cell hold, load the new item or take its upper
// neighbor, a pop shifts every cell down by one. All cells move in the same
// cycle, so one command is taken per clock while the receiver keeps up, and
// its result appears in the output register in the cycle after the transfer.
// The cycle time is set by one 32-bit signed compare per cell plus
// the fan-out of the command to all cells.
// While the receiver stalls a result waits in the output register and the
// input is held off until it is taken; no result is lost or repeated.
// Reset (rst, synchronous, active high) empties the queue and drops any
// pending result; cell contents are not cleared, the fill count marks them
// unused.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  // Input command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] item_value, [63:32] item_priority
  input  logic [0:0]  s_axis_tuser,  // [0] opcode
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [31:0] popped_value, [63:32] top_value,
                                     // [64] is_empty, [71:65] entry_count, rest 0
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int CAP = spq_pkg::CAPACITY;
  localparam int CW  = spq_pkg::CNT_W;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  spq_pkg::cell_ctrl_t  ctrl;
  spq_pkg::entry_t      new_entry;
  spq_pkg::entry_t      cell_entry [CAP];
  spq_pkg::entry_t      cell_next  [CAP];
  logic [CAP-1:0]       cell_keep;
  logic [CAP-1:0]       cell_occ;
  logic [1:0]           status;

  // Result register
  logic [1:0]           res_status;
  logic [31:0]          res_popped;
  logic [31:0]          res_top;
  logic                 res_empty;
  logic [6:0]           res_count;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count == CW'(CAP));
  assign empty         = (count == '0);
  assign new_entry.value = s_axis_tdata[31:0];
  assign new_entry.prio  = s_axis_tdata[63:32];

  // Decode the command into cell moves; rejected commands leave the row alone.
  always_comb begin
    ctrl.push  = 1'b0;
    ctrl.pop   = 1'b0;
    status     = spq_pkg::ST_DONE;
    count_next = count;
    if (accept) begin
      unique case (s_axis_tuser[0])
        spq_pkg::OP_PUSH: begin
          if (full) begin
            status = spq_pkg::ST_PUSH_FULL;
          end else begin
            ctrl.push  = 1'b1;
            count_next = count + CW'(1);
          end
        end
        spq_pkg::OP_POP: begin
          if (empty) begin
            status = spq_pkg::ST_POP_EMPTY;
          end else begin
            ctrl.pop   = 1'b1;
            count_next = count - CW'(1);
          end
        end
        default: status = spq_pkg::ST_DONE;
      endcase
    end
  end

  // Build the row of cells.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    assign cell_occ[i] = (count > CW'(i));
    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .occ        (cell_occ[i]),
      .prev_keep  ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i - 1]),
      .prev_entry (cell_entry[(i == 0) ? 0 : i - 1]),
      .next_entry (cell_entry[(i == CAP - 1) ? CAP - 1 : i + 1]),
      .keep       (cell_keep[i]),
      .entry      (cell_entry[i]),
      .entry_next (cell_next[i])
    );
  end

  // Track the fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Capture the result fields with the transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status;
      res_popped <= ctrl.pop ? cell_entry[0].value : 32'd0;
      res_top    <= (count_next != '0) ? cell_next[0].value : 32'd0;
      res_empty  <= (count_next == '0);
      res_count  <= 7'(count_next);
    end
  end

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = {8'd0, res_count, res_empty, res_top, res_popped};

  // Fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAP))
    else $error("fill count above capacity");

  // An accepted push with room grows the count by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    accept && (s_axis_tuser[0] == spq_pkg::OP_PUSH) && !full
      |=> count == $past(count) + CW'(1))
    else $error("push did not grow count");

  // The two top cells stay in priority order.
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(2) |-> $signed(cell_entry[0].prio) >= $signed(cell_entry[1].prio))
    else $error("head cells out of order");

  // A pop on an empty queue reports an empty queue.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (res_status == spq_pkg::ST_POP_EMPTY) |-> res_empty)
    else $error("empty pop with entries left");

endmodule

// ===== tb/sv/queue_result_checker.sv =====
// Checker for the sorted priority queue: tracks queue contents and compares every result.
`timescale 1ns / 1ps

module queue_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] item_value, [63:32] item_priority
  input  logic [0:0]  s_axis_tuser,  // [0] opcode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [79:0] m_axis_tdata,  // [31:0] popped_value, [63:32] top_value,
                                     // [64] is_empty, [71:65] entry_count, rest 0
  input  logic [1:0]  m_axis_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending,
  output int          n_push,
  output int          n_pop,
  output int          n_full,
  output int          n_empty,
  output int          peak_fill
);

  // Expected content of one result transfer.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped;
    logic [31:0] top;
    logic        empty;
    logic [6:0]  count;
  } outcome_t;

  // Shadow copy of the queue: slot 0 holds the highest priority.
  spq_pkg::entry_t shadow_slots [spq_pkg::CAPACITY];
  int              shadow_fill;
  outcome_t        pending_outcomes [$];
  int              n_results;

  // Print one line per mismatch, then count it.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    $display("[%0t] result %0d: %s mismatch, expected 0x%08h, got 0x%08h",
             $realtime, n_results, what, want, got);
  endtask

  // Apply one command to the shadow queue and queue its expected result.
  task automatic apply_queue_cmd(input logic op, input logic [31:0] val,
                                 input logic [31:0] pri);
    outcome_t res;
    int       pos;
    res        = '0;
    res.status = spq_pkg::ST_DONE;
    if (op == spq_pkg::OP_PUSH) begin
      n_push++;
      if (shadow_fill >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_PUSH_FULL;
        n_full++;
      end else begin
        // Go behind every entry of higher or equal priority.
        pos = 0;
        while (pos < shadow_fill && $signed(shadow_slots[pos].prio) >= $signed(pri))
          pos++;
        for (int i = shadow_fill; i > pos; i--)
          shadow_slots[i] = shadow_slots[i - 1];
        shadow_slots[pos].prio  = pri;
        shadow_slots[pos].value = val;
        shadow_fill++;
        if (shadow_fill > peak_fill)
          peak_fill = shadow_fill;
      end
    end else begin
      n_pop++;
      if (shadow_fill == 0) begin
        res.status = spq_pkg::ST_POP_EMPTY;
        n_empty++;
      end else begin
        res.popped = shadow_slots[0].value;
        for (int i = 1; i < shadow_fill; i++)
          shadow_slots[i - 1] = shadow_slots[i];
        shadow_fill--;
      end
    end
    res.top   = (shadow_fill > 0) ? shadow_slots[0].value : 32'd0;
    res.empty = (shadow_fill == 0);
    res.count = 7'(shadow_fill);
    pending_outcomes.push_back(res);
  endtask

  // Clear on reset; otherwise predict on each command transfer and compare each result.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      fail_count  = 0;
      pending     = 0;
      n_push      = 0;
      n_pop       = 0;
      n_full      = 0;
      n_empty     = 0;
      peak_fill   = 0;
      shadow_fill = 0;
      n_results   = 0;
      pending_outcomes.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_queue_cmd(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected result", 32'd0, m_axis_tdata[31:0]);
        end else begin
          want = pending_outcomes.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 32'(want.status), 32'(m_axis_tuser));
          if (m_axis_tdata[31:0] !== want.popped)
            report_mismatch("popped_value", want.popped, m_axis_tdata[31:0]);
          if (m_axis_tdata[63:32] !== want.top)
            report_mismatch("top_value", want.top, m_axis_tdata[63:32]);
          if (m_axis_tdata[64] !== want.empty)
            report_mismatch("is_empty", 32'(want.empty), 32'(m_axis_tdata[64]));
          if (m_axis_tdata[71:65] !== want.count)
            report_mismatch("entry_count", 32'(want.count), 32'(m_axis_tdata[71:65]));
          if (m_axis_tdata[79:72] !== 8'd0)
            report_mismatch("padding", 32'd0, 32'(m_axis_tdata[79:72]));
        end
      end
      pending = pending_outcomes.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the sorted priority queue: clock, reset, command traffic and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 5000;  // cycles without any transfer before giving up
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off to fill the pipeline

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;  // [31:0] item_value, [63:32] item_priority
  logic [0:0]  s_axis_tuser;  // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;  // [31:0] popped_value, [63:32] top_value,
                              // [64] is_empty, [71:65] entry_count, rest 0
  logic [1:0]  m_axis_tuser;  // [1:0] status

  int fail_count, pending, n_push, n_pop, n_full, n_empty, peak_fill;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_recv;

  sorted_priority_queue i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  queue_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .n_push        (n_push),
    .n_pop         (n_pop),
    .n_full        (n_full),
    .n_empty       (n_empty),
    .peak_fill     (peak_fill)
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, or hold off entirely while a fill-up runs.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready <= !hold_recv && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, pending results %0d",
             STALL_LIMIT, pending);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one command after a random idle gap; return at the falling edge after its transfer.
  task automatic send_cmd(input logic op, input logic [31:0] val, input logic [31:0] pri);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pri, val};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Mostly small priorities so ties are common, with extremes and full-range values mixed in.
  function automatic logic [31:0] pick_prio();
    logic [31:0] p;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       p = 32'h8000_0000;
          1:       p = 32'h7fff_ffff;
          2:       p = 32'h0000_0000;
          default: p = 32'hffff_ffff;
        endcase
      end
      1, 2:    p = $urandom;
      default: p = 32'($urandom_range(0, 15)) - 32'd8;
    endcase
    return p;
  endfunction

  // Run a block of commands with the given share of pushes.
  task automatic random_block(input int n_cmds, input int push_pct);
    for (int k = 0; k < n_cmds; k++)
      send_cmd(($urandom_range(0, 99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP,
               $urandom, pick_prio());
  endtask

  // One traffic phase: fill past capacity, drain past empty, then mixed traffic.
  task automatic traffic_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    random_block(110, 90);
    random_block(90, 12);
    random_block(60, 60);
    random_block(65, 35);
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = spq_pkg::OP_PUSH;
    hold_recv      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: pop on empty, extreme values, ties at head, middle and tail.
    send_cmd(spq_pkg::OP_POP, 32'hdead_beef, 32'h7fff_ffff);
    send_cmd(spq_pkg::OP_PUSH, 32'h8000_0000, 32'h8000_0000);
    send_cmd(spq_pkg::OP_PUSH, 32'h7fff_ffff, 32'h7fff_ffff);
    send_cmd(spq_pkg::OP_PUSH, 32'h0000_0001, 32'h7fff_ffff);
    send_cmd(spq_pkg::OP_PUSH, 32'h0000_0000, 32'h0000_0000);
    send_cmd(spq_pkg::OP_PUSH, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(spq_pkg::OP_PUSH, 32'h5555_5555, 32'h0000_0000);
    send_cmd(spq_pkg::OP_PUSH, 32'haaaa_aaaa, 32'h8000_0000);
    repeat (8) send_cmd(spq_pkg::OP_POP, $urandom, $urandom);
    send_cmd(spq_pkg::OP_PUSH, 32'hdead_beef, 32'h1234_5678);
    send_cmd(spq_pkg::OP_POP, 32'hffff_ffff, 32'hffff_ffff);

    // Random traffic under each idling pattern.
    traffic_phase(0, 0);
    traffic_phase(85, 0);
    traffic_phase(0, 85);
    traffic_phase(27, 27);

    // Back-pressure: keep offering commands while the receiver holds off.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_recv = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_recv = 1'b0;
      end
      random_block(150, 70);
    join
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle.
    while (pending != 0) @(negedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d pushes (%0d rejected as full) and %0d pops (%0d on an empty queue)",
             n_push, n_full, n_pop, n_empty);
    $display("deepest fill reached %0d of %0d entries", peak_fill, spq_pkg::CAPACITY);
    if (pending != 0)
      $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
